FILE: hw/rtl/ebmv_pkg.sv
// Types and constants for the element block gather multiply unit.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps
package ebmv_pkg;

   localparam logic [1:0] KIND_SOL_WRITE = 2'd0;
   localparam logic [1:0] KIND_MAT_WRITE = 2'd1;
   localparam logic [1:0] KIND_IDX_WRITE = 2'd2;
   localparam logic [1:0] KIND_RUN       = 2'd3;

   localparam int          CSR_DATA_W    = 13;
   localparam logic [0:0]  CSR_Y_COL_OFS = 1'd0;
   localparam logic [0:0]  CSR_Y_ROW_OFS = 1'd1;

   typedef struct packed {
      logic [1:0]         kind;
      logic [13:0]        address;
      logic signed [31:0] data;
      logic [13:0]        matrix_base;
      logic [4:0]         row_count;
      logic [4:0]         col_count;
      logic [12:0]        col_first;
      logic [12:0]        row_first;
   } req_type;

   typedef struct packed {
      logic [13:0]        result_row;
      logic signed [31:0] result_value;
      logic               saturated;
      logic               last;
   } rsp_type;

endpackage

FILE: hw/rtl/ebmv_if.sv
// Valid/ready channels for request and response words.
// Depends on ebmv_pkg.
`timescale 1ns / 1ps
interface ebmv_req_if;
   logic              valid;
   logic              ready;
   ebmv_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ebmv_rsp_if;
   logic              valid;
   logic              ready;
   ebmv_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/element_block_matvec_gather_unit.sv
// Gathered element matrix times vector unit, x and y results per row.
// Depends on ebmv_pkg and the channels in ebmv_if.
// A run word yields, per row, an x then a y word, each produced by the single
// multiply-accumulate pipeline (matrix and index reads, solution read, multiply,
// accumulate) and then held until the output is taken.
// Write words are taken one a cycle, but only while idle; no request is taken during a run.
// Reset: synchronous, clears control state and offsets; store contents stay undefined.
`timescale 1ns / 1ps
module element_block_matvec_gather_unit #(
   parameter int SOL_DEPTH = 4096,
   parameter int MAT_DEPTH = 16384,
   parameter int IDX_DEPTH = 8192,
   parameter int MAX_ROWS  = 16,
   parameter int MAX_COLS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   ebmv_req_if.sink                        req,
   ebmv_rsp_if.source                      rsp,
   input  logic                            csr_write_enable,
   input  logic [0:0]                      csr_index,
   input  logic [ebmv_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int SA_W  = $clog2(SOL_DEPTH);
   localparam int MA_W  = $clog2(MAT_DEPTH);
   localparam int IA_W  = $clog2(IDX_DEPTH);
   localparam int SX_W  = (SA_W > 14) ? SA_W : 14;
   localparam int MX_W  = (MA_W > 16) ? MA_W : 16;
   localparam int IX_W  = (IA_W > 16) ? IA_W : 16;
   localparam int CNT_W = 7;
   localparam int ACC_W = 64 + CNT_W;
   localparam int RND_W = ACC_W - 16;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [31:0] sol_mem [SOL_DEPTH];
   logic [31:0] mat_mem [MAT_DEPTH];
   logic [11:0] idx_mem [IDX_DEPTH];

   logic [1:0]        state_ff, state_in;
   logic [12:0]       ycol_ff, yrow_ff;
   logic [13:0]       base_ff;
   logic [CNT_W-1:0]  rows_ff, cols_ff, r_ff, c_ff, r_in, c_in;
   logic [12:0]       cfirst_ff, rfirst_ff;
   logic              dir_ff, dir_in;
   logic              acc_clr;

   logic              b_v_ff, b_mok_ff, b_iok_ff;
   logic              c_v_ff, c_sok_ff;
   logic              d_v_ff;
   logic [31:0]       mat_q_ff, sol_q_ff, c_mat_ff;
   logic [11:0]       idx_q_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   ebmv_pkg::rsp_type rsp_ff;

   ebmv_pkg::req_type rq;
   logic              acc_req, issue;
   logic [CNT_W-1:0]  rows_clip, cols_clip;
   logic [MX_W-1:0]   mat_addr, wr_mat_addr;
   logic [IX_W-1:0]   idx_addr, wr_idx_addr;
   logic [SX_W-1:0]   sol_addr, wr_sol_addr;
   logic              mat_ok, idx_ok, sol_ok;
   logic signed [ACC_W-1:0] rnd_sum;
   logic signed [RND_W-1:0] rnd_val;
   logic signed [31:0] m_op, s_op;

   assign rq      = req.payload;
   assign acc_req = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_EMIT);
   assign rsp.payload = rsp_ff;
   assign issue   = (state_ff == ST_ISSUE) && (c_ff != cols_ff);

   assign rows_clip = (32'(rq.row_count) > 32'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                           : CNT_W'(rq.row_count);
   assign cols_clip = (32'(rq.col_count) > 32'(MAX_COLS)) ? CNT_W'(MAX_COLS)
                                                           : CNT_W'(rq.col_count);

   assign mat_addr = MX_W'(base_ff) + MX_W'(c_ff) * MX_W'(rows_ff) + MX_W'(r_ff);
   assign idx_addr = IX_W'(cfirst_ff) + IX_W'(c_ff) + (dir_ff ? IX_W'(ycol_ff) : '0);
   assign sol_addr = SX_W'(idx_q_ff);
   assign mat_ok   = 32'(mat_addr) < 32'(MAT_DEPTH);
   assign idx_ok   = 32'(idx_addr) < 32'(IDX_DEPTH);
   assign sol_ok   = b_iok_ff && (32'(idx_q_ff) < 32'(SOL_DEPTH));
   assign wr_mat_addr = MX_W'(rq.address);
   assign wr_idx_addr = IX_W'(rq.address);
   assign wr_sol_addr = SX_W'(rq.address);

   // storage: write from request words while idle, read by the pipeline
   always_ff @(posedge clock) begin
      if (acc_req && rq.kind == ebmv_pkg::KIND_MAT_WRITE &&
          32'(rq.address) < 32'(MAT_DEPTH)) begin
         mat_mem[wr_mat_addr[MA_W-1:0]] <= rq.data;
      end
      mat_q_ff <= mat_mem[mat_addr[MA_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (acc_req && rq.kind == ebmv_pkg::KIND_IDX_WRITE &&
          32'(rq.address) < 32'(IDX_DEPTH)) begin
         idx_mem[wr_idx_addr[IA_W-1:0]] <= rq.data[11:0];
      end
      idx_q_ff <= idx_mem[idx_addr[IA_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (acc_req && rq.kind == ebmv_pkg::KIND_SOL_WRITE &&
          32'(rq.address) < 32'(SOL_DEPTH)) begin
         sol_mem[wr_sol_addr[SA_W-1:0]] <= rq.data;
      end
      sol_q_ff <= sol_mem[sol_addr[SA_W-1:0]];
   end

   // multiply-accumulate pipeline
   assign m_op = c_mat_ff;
   assign s_op = c_sok_ff ? sol_q_ff : 32'sd0;

   always_ff @(posedge clock) begin
      c_mat_ff <= b_mok_ff ? mat_q_ff : 32'd0;
      c_sok_ff <= sol_ok;
      prod_ff  <= m_op * s_op;
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (d_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         b_v_ff <= issue;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_mok_ff <= mat_ok;
      b_iok_ff <= idx_ok;
   end

   // round to nearest, ties up, then clip
   assign rnd_sum = acc_ff + ACC_W'(32768);
   assign rnd_val = RND_W'(rnd_sum >>> 16);

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      dir_in   = dir_ff;
      acc_clr  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (acc_req && rq.kind == ebmv_pkg::KIND_RUN && rows_clip != '0) begin
               state_in = ST_ISSUE;
               r_in     = '0;
               c_in     = '0;
               dir_in   = 1'b0;
               acc_clr  = 1'b1;
            end
         end
         ST_ISSUE: begin
            if (c_ff == cols_ff) begin
               state_in = ST_DRAIN;
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!b_v_ff && !c_v_ff && !d_v_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               c_in    = '0;
               acc_clr = 1'b1;
               if (!dir_ff) begin
                  dir_in   = 1'b1;
                  state_in = ST_ISSUE;
               end else if (r_ff + 1'b1 == rows_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  dir_in   = 1'b0;
                  r_in     = r_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ycol_ff  <= '0;
         yrow_ff  <= '0;
         r_ff     <= '0;
         c_ff     <= '0;
         dir_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         dir_ff   <= dir_in;
         if (csr_write_enable && csr_index == ebmv_pkg::CSR_Y_COL_OFS) begin
            ycol_ff <= csr_write_data;
         end
         if (csr_write_enable && csr_index == ebmv_pkg::CSR_Y_ROW_OFS) begin
            yrow_ff <= csr_write_data;
         end
      end
   end

   // hold element geometry and the result word
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && acc_req && rq.kind == ebmv_pkg::KIND_RUN) begin
         base_ff   <= rq.matrix_base;
         rows_ff   <= rows_clip;
         cols_ff   <= cols_clip;
         cfirst_ff <= rq.col_first;
         rfirst_ff <= rq.row_first;
      end
      if (state_ff == ST_DRAIN) begin
         rsp_ff.result_row <= 14'(rfirst_ff) + 14'(r_ff) + (dir_ff ? 14'(yrow_ff) : 14'd0);
         rsp_ff.last       <= dir_ff && (r_ff + 1'b1 == rows_ff);
         if (rnd_val > RND_W'(32'sh7FFF_FFFF)) begin
            rsp_ff.result_value <= 32'sh7FFF_FFFF;
            rsp_ff.saturated    <= 1'b1;
         end else if (rnd_val < RND_W'(32'sh8000_0000)) begin
            rsp_ff.result_value <= 32'sh8000_0000;
            rsp_ff.saturated    <= 1'b1;
         end else begin
            rsp_ff.result_value <= 32'(rnd_val);
            rsp_ff.saturated    <= 1'b0;
         end
      end
   end

endmodule
